// ===== rtl/jdcal_pkg.sv =====
// ============================================================================
// jdcal_pkg: shared constants for the Julian date to calendar converter
// Holds the calendar constants, the fixed reciprocal multipliers that replace
// the constant divisions, and the decimal scale lookup for the seconds field.
// ============================================================================
package jdcal_pkg;

    // Time of day constants in whole seconds.
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [16:0] HALF_DAY     = 17'd43200;
    localparam logic [17:0] TWO_DAYS     = 18'd172800;

    // Rounding bias for the sub-second product, one half in units of 2^-32.
    localparam logic [52:0] ROUND_HALF = 53'h0_0000_8000_0000;

    // First day number that takes the Gregorian correction.
    localparam logic signed [23:0] GREG_DAY = 24'sd2299160;

    // 4 * 1867216 + 1, the bias of the century count numerator.
    localparam logic [25:0] GREG_BIAS = 26'd7468865;

    // Calendar offsets.
    localparam logic [22:0] J2_OFFSET = 23'd1524;
    localparam logic [28:0] J3_BIAS   = 29'd12210;
    localparam logic signed [14:0] YEAR_BASE = 15'sd4715;

    // Largest supported number of decimal places.
    localparam logic [2:0] MAX_DECIMALS = 3'd6;

    // Reciprocal multipliers. Each is ceil(2^K * a / d) with K chosen large
    // enough that the truncated product equals the floor of the quotient
    // over the whole input range of that stage.
    // Century count: x / 146097 for x < 2^24.
    localparam int          T_SHIFT = 42;
    localparam logic [24:0] T_MULT  =
        25'(((longint'(1) <<< T_SHIFT) + 146096) / 146097);

    // Year count: x / 36525 for x < 2^29.
    localparam int          J3_SHIFT = 45;
    localparam logic [29:0] J3_MULT  =
        30'(((longint'(1) <<< J3_SHIFT) + 36524) / 36525);

    // Month count: x * 10000 / 306001 for x < 2^11.
    localparam int          J5_SHIFT = 30;
    localparam logic [25:0] J5_MULT  =
        26'(((longint'(1) <<< J5_SHIFT) * 10000 + 306000) / 306001);

    // Days before the month: x * 306001 / 10000 for x < 2^5.
    localparam int          MD_SHIFT = 19;
    localparam logic [23:0] MD_MULT  =
        24'(((longint'(1) <<< MD_SHIFT) * 306001 + 9999) / 10000);

    // Seconds to minutes: x / 60 for x < 2^17.
    localparam int          MIN_SHIFT = 23;
    localparam logic [17:0] MIN_MULT  =
        18'(((longint'(1) <<< MIN_SHIFT) + 59) / 60);

    // Minutes to hours: x / 60 for x < 2^11.
    localparam int          HOUR_SHIFT = 17;
    localparam logic [11:0] HOUR_MULT  =
        12'(((longint'(1) <<< HOUR_SHIFT) + 59) / 60);

    // Ten to the power of the decimal count; counts above six saturate.
    function automatic logic [19:0] dec_scale(input logic [2:0] dec);
        logic [19:0] scale;
        case (dec)
            3'd0:    scale = 20'd1;
            3'd1:    scale = 20'd10;
            3'd2:    scale = 20'd100;
            3'd3:    scale = 20'd1000;
            3'd4:    scale = 20'd10000;
            3'd5:    scale = 20'd100000;
            default: scale = 20'd1000000;
        endcase
        return scale;
    endfunction

endpackage

// ===== rtl/julian_date_to_calendar.sv =====
// ============================================================================
// julian_date_to_calendar: Julian date to calendar date and time of day
// Converts a fixed point Julian date plus a local offset into year, month,
// day, hour, minute and rounded seconds in a ten stage pipeline.
// ============================================================================
//
//  Channel  | Dir | Handshake            | Fields
//  ---------+-----+----------------------+---------------------------------------
//  input    | in  | start, busy          | julian_date
//  result   | out | done (one cycle)     | year, month, day_of_month, hour,
//           |     |                      | minute, second_scaled
//  config   | in  | psel, penable, pwrite| paddr, pwdata, prdata, pready
//
//  One item is accepted every cycle; busy stays low.
//  Each result passes through the ten register stages of the date and
//  time datapath.
//  Reset clears the stage valid bits and both configuration registers.
//  The receiver cannot stall, so the pipeline advances every cycle.
//
module julian_date_to_calendar
    import jdcal_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input item
    input  logic               start,
    output logic               busy,
    input  logic [53:0]        julian_date,
    // Result item
    output logic               done,
    output logic signed [13:0] year,
    output logic [3:0]         month,
    output logic [4:0]         day_of_month,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [25:0]        second_scaled
);

    localparam int PIPE_DEPTH = 10;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic signed [17:0] utc_off_reg;
    logic [2:0]         dec_reg;
    logic               cfg_wr;
    logic [2:0]         dec_sat;
    logic [19:0]        p_cur;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // Register 0 sits at byte 0, register 1 at byte 4.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utc_off_reg <= '0;
            dec_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
            begin
                dec_reg <= pwdata[2:0];
            end
            else
            begin
                utc_off_reg <= pwdata[17:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2])
        begin
            prdata = {29'd0, dec_reg};
        end
        else
        begin
            prdata = 32'(utc_off_reg);
        end
    end

    // Decimal count saturates at six; the scale is shared by stages 2, 3 and 9.
    assign dec_sat = (dec_reg > MAX_DECIMALS) ? MAX_DECIMALS : dec_reg;
    assign p_cur   = dec_scale(dec_sat);

    // ------------------------------------------------------------------------
    // Valid bits, one per stage
    // ------------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] vld_next;

    assign busy     = 1'b0;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign done = vld_reg[PIPE_DEPTH-1];

    // ------------------------------------------------------------------------
    // Stage 1: day fraction to seconds in units of 2^-32 second.
    // ------------------------------------------------------------------------
    logic [48:0] frac_prod;
    logic [21:0] day1_reg;
    logic [16:0] ahi1_reg;
    logic [31:0] alo1_reg;

    assign frac_prod = 49'(julian_date[31:0]) * 49'(SECS_PER_DAY);

    always_ff @(posedge clk)
    begin
        day1_reg <= julian_date[53:32];
        ahi1_reg <= frac_prod[48:32];
        alo1_reg <= frac_prod[31:0];
    end

    // ------------------------------------------------------------------------
    // Stage 2: add the offset and fold into one day; round the sub-second part.
    // ------------------------------------------------------------------------
    logic signed [19:0] secs;
    logic signed [19:0] secs_norm;
    logic signed [2:0]  day_step;
    logic [52:0]        rnd_prod;
    logic signed [23:0] day2_reg;
    logic [16:0]        sec2_reg;
    logic [19:0]        rnd2_reg;

    assign secs = $signed({3'b000, ahi1_reg}) + 20'(utc_off_reg);

    always_comb
    begin
        if (secs < -$signed({3'b000, SECS_PER_DAY}))
        begin
            day_step  = -3'sd2;
            secs_norm = secs + $signed({2'b00, TWO_DAYS});
        end
        else if (secs < 20'sd0)
        begin
            day_step  = -3'sd1;
            secs_norm = secs + $signed({3'b000, SECS_PER_DAY});
        end
        else if (secs < $signed({3'b000, SECS_PER_DAY}))
        begin
            day_step  = 3'sd0;
            secs_norm = secs;
        end
        else if (secs < $signed({2'b00, TWO_DAYS}))
        begin
            day_step  = 3'sd1;
            secs_norm = secs - $signed({3'b000, SECS_PER_DAY});
        end
        else
        begin
            day_step  = 3'sd2;
            secs_norm = secs - $signed({2'b00, TWO_DAYS});
        end
    end

    assign rnd_prod = 53'(alo1_reg) * 53'(p_cur) + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        day2_reg <= $signed({2'b00, day1_reg}) + 24'(day_step);
        sec2_reg <= secs_norm[16:0];
        rnd2_reg <= rnd_prod[51:32];
    end

    // ------------------------------------------------------------------------
    // Stage 3: rounding carry into seconds and past midnight into the day.
    // ------------------------------------------------------------------------
    logic [16:0]        sec_carry;
    logic [19:0]        rem_carry;
    logic signed [23:0] day3_reg;
    logic [16:0]        s3_reg;
    logic [19:0]        r3_reg;

    always_comb
    begin
        if (rnd2_reg == p_cur)
        begin
            sec_carry = sec2_reg + 17'd1;
            rem_carry = '0;
        end
        else
        begin
            sec_carry = sec2_reg;
            rem_carry = rnd2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r3_reg <= rem_carry;
        if (sec_carry == SECS_PER_DAY)
        begin
            s3_reg   <= '0;
            day3_reg <= day2_reg + 24'sd1;
        end
        else
        begin
            s3_reg   <= sec_carry;
            day3_reg <= day2_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: Gregorian test and century count.
    // ------------------------------------------------------------------------
    logic               greg;
    logic [25:0]        cent_num;
    logic [48:0]        cent_prod;
    logic               greg4_reg;
    logic [6:0]         t4_reg;
    logic signed [23:0] day4_reg;
    logic [16:0]        s4_reg;
    logic [19:0]        r4_reg;

    assign greg = (day3_reg > GREG_DAY) ||
                  ((day3_reg == GREG_DAY) && (s3_reg >= HALF_DAY));
    assign cent_num  = {day3_reg[23:0], 2'b00} - GREG_BIAS;
    assign cent_prod = 49'(cent_num[23:0]) * 49'(T_MULT);

    always_ff @(posedge clk)
    begin
        greg4_reg <= greg;
        t4_reg    <= cent_prod[48:T_SHIFT];
        day4_reg  <= day3_reg;
        s4_reg    <= s3_reg;
        r4_reg    <= r3_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 5: apply the correction and the half-day shift.
    // ------------------------------------------------------------------------
    logic [6:0]         greg_adj;
    logic [16:0]        sec_shift;
    logic               half_carry;
    logic signed [23:0] day5_reg;
    logic [16:0]        s5_reg;
    logic [19:0]        r5_reg;

    assign greg_adj   = greg4_reg ? (7'd1 + t4_reg - {2'b00, t4_reg[6:2]}) : 7'd0;
    assign sec_shift  = s4_reg + HALF_DAY;
    assign half_carry = (sec_shift >= SECS_PER_DAY);

    always_ff @(posedge clk)
    begin
        day5_reg <= day4_reg + $signed({17'd0, greg_adj}) + $signed({23'd0, half_carry});
        s5_reg   <= half_carry ? (sec_shift - SECS_PER_DAY) : sec_shift;
        r5_reg   <= r4_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 6: year count numerator; seconds to minutes.
    // ------------------------------------------------------------------------
    logic [22:0] j2;
    logic [34:0] min_prod;
    logic [22:0] j2_6_reg;
    logic [28:0] x6_reg;
    logic [10:0] mt6_reg;
    logic [16:0] s6_reg;
    logic [19:0] r6_reg;

    assign j2       = day5_reg[22:0] + J2_OFFSET;
    assign min_prod = 35'(s5_reg) * 35'(MIN_MULT);

    always_ff @(posedge clk)
    begin
        j2_6_reg <= j2;
        x6_reg   <= 29'(j2) * 29'd100 - J3_BIAS;
        mt6_reg  <= min_prod[33:MIN_SHIFT];
        s6_reg   <= s5_reg;
        r6_reg   <= r5_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 7: year count; minutes to hours.
    // ------------------------------------------------------------------------
    logic [58:0] j3_prod;
    logic [22:0] hour_prod;
    logic [22:0] j2_7_reg;
    logic [13:0] j3_7_reg;
    logic [4:0]  hour7_reg;
    logic [10:0] mt7_reg;
    logic [16:0] s7_reg;
    logic [19:0] r7_reg;

    assign j3_prod   = 59'(x6_reg) * 59'(J3_MULT);
    assign hour_prod = 23'(mt6_reg) * 23'(HOUR_MULT);

    always_ff @(posedge clk)
    begin
        j2_7_reg  <= j2_6_reg;
        j3_7_reg  <= j3_prod[58:J3_SHIFT];
        hour7_reg <= hour_prod[21:HOUR_SHIFT];
        mt7_reg   <= mt6_reg;
        s7_reg    <= s6_reg;
        r7_reg    <= r6_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 8: day within the shifted year; minute and second remainders.
    // ------------------------------------------------------------------------
    logic [24:0] j4_prod;
    logic [22:0] day_in_year;
    logic [10:0] hour_mins;
    logic [10:0] min_rem;
    logic [16:0] min_secs;
    logic [16:0] sec_rem;
    logic [10:0] dj8_reg;
    logic [13:0] j3_8_reg;
    logic [4:0]  hour8_reg;
    logic [5:0]  minute8_reg;
    logic [5:0]  sec8_reg;
    logic [19:0] r8_reg;

    assign j4_prod     = 25'(j3_7_reg) * 25'd1461;
    assign day_in_year = j2_7_reg - j4_prod[24:2];
    assign hour_mins   = 11'(hour7_reg) * 11'd60;
    assign min_rem     = mt7_reg - hour_mins;
    assign min_secs    = 17'(mt7_reg) * 17'd60;
    assign sec_rem     = s7_reg - min_secs;

    always_ff @(posedge clk)
    begin
        dj8_reg     <= day_in_year[10:0];
        j3_8_reg    <= j3_7_reg;
        hour8_reg   <= hour7_reg;
        minute8_reg <= min_rem[5:0];
        sec8_reg    <= sec_rem[5:0];
        r8_reg      <= r7_reg;
    end

    // ------------------------------------------------------------------------
    // Stage 9: month count; scaled seconds.
    // ------------------------------------------------------------------------
    logic [36:0] j5_prod;
    logic [4:0]  j5_9_reg;
    logic [10:0] dj9_reg;
    logic [13:0] j3_9_reg;
    logic [4:0]  hour9_reg;
    logic [5:0]  minute9_reg;
    logic [25:0] ssc9_reg;

    assign j5_prod = 37'(dj8_reg) * 37'(J5_MULT);

    always_ff @(posedge clk)
    begin
        j5_9_reg    <= j5_prod[34:J5_SHIFT];
        dj9_reg     <= dj8_reg;
        j3_9_reg    <= j3_8_reg;
        hour9_reg   <= hour8_reg;
        minute9_reg <= minute8_reg;
        ssc9_reg    <= 26'(sec8_reg) * 26'(p_cur) + 26'(r8_reg);
    end

    // ------------------------------------------------------------------------
    // Stage 10: day of month, month and year; output registers.
    // ------------------------------------------------------------------------
    logic [28:0]        md_prod;
    logic [10:0]        dom_full;
    logic [4:0]         mon_raw;
    logic [4:0]         mon_fix;
    logic signed [14:0] year_raw;
    logic signed [14:0] year_fix;
    logic signed [13:0] year_reg;
    logic [3:0]         month_reg;
    logic [4:0]         dom_reg;
    logic [4:0]         hour_reg;
    logic [5:0]         minute_reg;
    logic [25:0]        ssc_reg;

    assign md_prod  = 29'(j5_9_reg) * 29'(MD_MULT);
    assign dom_full = dj9_reg - 11'(md_prod[28:MD_SHIFT]);
    assign mon_raw  = j5_9_reg - 5'd1;
    assign mon_fix  = (mon_raw > 5'd12) ? (mon_raw - 5'd12) : mon_raw;

    // No year zero: years at or below zero move down by one.
    always_comb
    begin
        year_raw = $signed({1'b0, j3_9_reg}) - YEAR_BASE
                   - $signed({14'd0, (mon_fix > 5'd2)});
        if (year_raw <= 15'sd0)
        begin
            year_fix = year_raw - 15'sd1;
        end
        else
        begin
            year_fix = year_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg   <= year_fix[13:0];
        month_reg  <= mon_fix[3:0];
        dom_reg    <= dom_full[4:0];
        hour_reg   <= hour9_reg;
        minute_reg <= minute9_reg;
        ssc_reg    <= ssc9_reg;
    end

    assign year          = year_reg;
    assign month         = month_reg;
    assign day_of_month  = dom_reg;
    assign hour          = hour_reg;
    assign minute        = minute_reg;
    assign second_scaled = ssc_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Every accepted item leaves the pipeline as a result, in the order of acceptance.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("accepted item did not produce a result on time");

    // No result appears without an item accepted at the right time.
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without a matching accepted item");

    // Month, hour and minute of a result are in calendar range; the day is nonzero.
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month != 4'd0 && month <= 4'd12 && day_of_month != 5'd0 &&
                  hour < 5'd24 && minute < 6'd60))
        else $error("result field out of calendar range");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: Julian date to calendar converter testbench
// Streams Julian dates into the converter under several offset and rounding
// settings. A predictor written here in exact integer arithmetic computes the
// calendar date and time of each accepted item, and every result is checked
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] ADDR_UTC_OFFSET      = 3'd0;
    localparam logic [2:0] ADDR_SECOND_DECIMALS = 3'd4;

    // Calendar and time constants for the predictor.
    localparam longint FRAC_ONE       = 64'sd4294967296;
    localparam longint DAY_SECS       = 86400;
    localparam longint HALF_DAY_SECS  = 43200;
    localparam longint DAY_UNITS      = DAY_SECS * FRAC_ONE;
    localparam longint GREG_START_DAY = 2299160;
    localparam int     MAX_PLACES     = 6;

    // Run control.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHOW_LIMIT   = 100;

    typedef struct packed {
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [25:0]        second_scaled;
    } calendar_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic [53:0]        julian_date;
    logic               done;
    logic signed [13:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [25:0]        second_scaled;

    // Shadow copies of the configuration registers.
    logic signed [17:0] offset_cfg   = '0;
    logic [2:0]         decimals_cfg = '0;

    calendar_t pending_dates[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;

    julian_date_to_calendar dut (.*);

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor division for a positive divisor.
    function automatic longint floor_div(input longint num, input longint den);
        longint quo;
        quo = num / den;
        if ((num % den) != 0 && num < 0)
            quo = quo - 1;
        return quo;
    endfunction

    // Predicts the calendar date and time of one Julian date.
    function automatic calendar_t jd_to_calendar(input logic [53:0] jd,
                                                 input logic signed [17:0] offset,
                                                 input logic [2:0] decimals);
        longint    day, s, carry, scale, q, day_q, half_q, t;
        longint    j2, j3, j4, j5, dom, mon, yr, per_min;
        int        places;
        calendar_t r;

        // Add the offset and split into whole days and time of day.
        day   = longint'(jd[53:32]);
        s     = longint'(jd[31:0]) * DAY_SECS + longint'(offset) * FRAC_ONE;
        carry = floor_div(s, DAY_UNITS);
        day   = day + carry;
        s     = s - carry * DAY_UNITS;

        // Round the time of day half up to the chosen decimal step.
        places = (decimals > MAX_PLACES) ? MAX_PLACES : int'(decimals);
        scale  = 1;
        repeat (places) scale = scale * 10;
        q = (s >>> 32) * scale + (((s & 64'hFFFF_FFFF) * scale + 64'h8000_0000) >> 32);
        day_q  = DAY_SECS * scale;
        half_q = HALF_DAY_SECS * scale;
        if (q >= day_q)
        begin
            q   = q - day_q;
            day = day + 1;
        end

        // Gregorian correction from the switch-over instant onward.
        if (day > GREG_START_DAY || (day == GREG_START_DAY && q >= half_q))
        begin
            t   = (4 * (day - 1867216) - 1) / 146097;
            day = day + 1 + t - t / 4;
        end

        // Move the start of the day from noon to midnight.
        q = q + half_q;
        if (q >= day_q)
        begin
            q   = q - day_q;
            day = day + 1;
        end

        // Calendar date.
        j2  = day + 1524;
        j3  = 6680 + floor_div(100 * (j2 - 2439870) - 12210, 36525);
        j4  = floor_div(j3 * 1461, 4);
        j5  = floor_div((j2 - j4) * 10000, 306001);
        dom = j2 - j4 - floor_div(j5 * 306001, 10000);
        mon = j5 - 1;
        if (mon > 12)
            mon = mon - 12;
        yr = j3 - 4715;
        if (mon > 2)
            yr = yr - 1;
        if (yr <= 0)
            yr = yr - 1;

        per_min         = 60 * scale;
        r.year          = yr[13:0];
        r.month         = mon[3:0];
        r.day_of_month  = dom[4:0];
        r.hour          = 5'(q / (60 * per_min));
        r.minute        = 6'((q / per_min) % 60);
        r.second_scaled = 26'(q % per_min);
        return r;
    endfunction

    // Prints one mismatch line, up to a cap, and counts every mismatch.
    task automatic report_mismatch(input string what);
        if (mismatch_count < SHOW_LIMIT)
            $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Checks each result against the oldest prediction and records each item.
    always @(posedge clk)
    begin : result_check
        calendar_t got;
        calendar_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{year, month, day_of_month, hour, minute, second_scaled};
                if (pending_dates.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    want = pending_dates.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "got %0d-%0d-%0d %0d:%0d s%0d, expected %0d-%0d-%0d %0d:%0d s%0d",
                            got.year, got.month, got.day_of_month, got.hour,
                            got.minute, got.second_scaled,
                            want.year, want.month, want.day_of_month, want.hour,
                            want.minute, want.second_scaled));
                end
            end
            if (start && !busy)
                pending_dates.push_back(jd_to_calendar(julian_date, offset_cfg, decimals_cfg));
        end
    end

    // Ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Gap length: often none, mostly short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Random Julian date, weighted toward the interesting regions.
    function automatic logic [53:0] pick_jd();
        logic [21:0] day;
        logic [31:0] frac;
        day  = 22'($urandom);
        frac = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4:    day = 22'($urandom_range(0, 2600000));
            5:       day = 22'(GREG_START_DAY - 2 + $urandom_range(0, 4));
            6:       frac = 32'hFFFF_FFFF - $urandom_range(0, 100000);
            7:       day = 22'($urandom_range(0, 3));
            8:       day = 22'h3F_FFFF - 22'($urandom_range(0, 3));
            // Sub-second part exactly one half at whole-second rounding.
            default: frac = {frac[31:25], 1'b1, 24'h0};
        endcase
        return {day, frac};
    endfunction

    // Presents one item and waits until it is taken.
    task automatic send_jd(input logic [53:0] jd);
        @(negedge clk);
        start       <= 1'b1;
        julian_date <= jd;
        do @(posedge clk); while (busy);
    endtask

    // Holds the input idle for a number of cycles.
    task automatic pause_stream(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            start       <= 1'b0;
            julian_date <= {22'($urandom), $urandom};
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic drain();
        if (start)
            pause_stream(1);
        while (pending_dates.size() != 0) @(posedge clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_UTC_OFFSET)
            offset_cfg = data[17:0];
        else if (addr == ADDR_SECOND_DECIMALS)
            decimals_cfg = data[2:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Changes both registers once the converter is idle.
    task automatic configure(input logic signed [17:0] offset, input logic [2:0] decimals);
        drain();
        write_reg(ADDR_UTC_OFFSET, 32'(offset));
        write_reg(ADDR_SECOND_DECIMALS, {29'd0, decimals});
    endtask

    task automatic send_gapped(input logic [53:0] jd);
        send_jd(jd);
        pause_stream(pick_gap());
    endtask

    // Reset settings: field extremes, a known epoch, an exact half second,
    // and the Gregorian switch-over instant with the instant just before it.
    task automatic test_reset_defaults();
        send_gapped(54'd0);
        send_gapped({54{1'b1}});
        send_gapped({22'd2451545, 32'h0000_0000});
        send_gapped({22'd2451545, 32'h0100_0000});
        send_gapped({22'(GREG_START_DAY), 32'h8000_0000});
        send_gapped({22'(GREG_START_DAY), 32'h7FFF_0000});
    endtask

    // Rounding that carries into the next day, and a carry that crosses
    // the Gregorian switch-over.
    task automatic test_rounding_carry();
        logic [2:0] places[3] = '{3'd0, 3'd3, 3'd6};
        foreach (places[i])
        begin
            configure(18'sd0, places[i]);
            send_gapped({22'd2451544, 32'hFFFF_FFFF});
            send_gapped({22'(GREG_START_DAY), 32'h7FFF_FFFF});
        end
    endtask

    // Offsets at and beyond one day either way, including dates pushed
    // below day zero.
    task automatic test_offset_extremes();
        configure(-18'sd131072, 3'd0);
        send_gapped(54'd0);
        send_gapped({22'(GREG_START_DAY), 32'h8000_0000});
        configure(18'sd131071, 3'd6);
        send_gapped({54{1'b1}});
        send_gapped(54'd0);
        configure(-18'sd86400, 3'd2);
        send_gapped({22'd0, $urandom});
        send_gapped({22'(GREG_START_DAY + 1), 32'h0000_0000});
        configure(18'sd86400, 3'd5);
        send_gapped({22'(GREG_START_DAY - 1), 32'h8000_0000});
        send_gapped({22'h3F_FFFF, 32'h0000_0000});
    endtask

    // A decimal count above six behaves as six.
    task automatic test_decimal_saturation();
        configure(-18'sd1, 3'd7);
        send_gapped({22'd2451545, 32'hFFFF_FFFF});
        send_gapped({22'd1234567, 32'h0100_0000});
    endtask

    // Random dates under random settings; each phase drains once midway.
    task automatic test_random_stream(input int phases, input int per_phase);
        logic signed [17:0] offset;
        bit                 burst;
        for (int ph = 0; ph < phases; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       offset = -18'sd131072;
                1:       offset = 18'sd131071;
                2:       offset = 18'sd0;
                default: offset = 18'($urandom);
            endcase
            configure(offset, 3'($urandom_range(0, 7)));
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < per_phase; i++)
            begin
                if (i == per_phase / 2)
                    drain();
                send_jd(pick_jd());
                pause_stream(burst ? 0 : pick_gap());
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        start       = 1'b0;
        julian_date = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_rounding_carry();
        test_offset_extremes();
        test_decimal_saturation();
        test_random_stream(8, 165);

        // Let the last results through, then keep watching for strays.
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
